>>> design/nalsplit_pkg.sv
// Shared types and constants for the Annex B access unit splitter.
`timescale 1ns / 1ps
package nalsplit_pkg;

  // Stream constants
  localparam int unsigned TYPE_BITS   = 5;
  localparam logic [7:0]  TYPE_FIELD  = 8'h1F;
  localparam logic [7:0]  START_BYTE  = 8'h01;
  localparam logic [31:0] MASK_RESET  = 32'h0000_0022;

  // Delay line and result batch sizes
  localparam int unsigned DLY_DEPTH   = 4;
  localparam int unsigned WIN_DEPTH   = DLY_DEPTH + 1;
  localparam int unsigned MAX_RES     = WIN_DEPTH;
  localparam int unsigned Q_DEPTH     = MAX_RES + 1;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned QCNT_W      = 3;

  // One output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       closed;
  } res_t;

  // Results produced by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    res_t [MAX_RES-1:0]            res;
  } batch_t;

endpackage

>>> design/nalsplit_step.sv
// Start-code parser, packet marking and four-byte delay line.
`timescale 1ns / 1ps
module nalsplit_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            stream_byte,
  input  logic                  end_of_stream,
  input  logic [31:0]           closing_type_mask,
  output nalsplit_pkg::batch_t  batch
);
  import nalsplit_pkg::*;

  // Stream state
  logic [DLY_DEPTH-1:0][7:0] dly_bytes;
  logic [DLY_DEPTH-1:0]      dly_first;
  logic [DLY_DEPTH-1:0]      dly_last;
  logic [CNT_W-1:0]          dly_count;
  logic [1:0]                zero_run;
  logic                      in_packet;
  logic                      header_pending;
  logic                      nal_closes;

  logic [DLY_DEPTH-1:0][7:0] dly_bytes_next;
  logic [DLY_DEPTH-1:0]      dly_first_next;
  logic [DLY_DEPTH-1:0]      dly_last_next;
  logic [CNT_W-1:0]          dly_count_next;
  logic [1:0]                zero_run_next;
  logic                      in_packet_next;
  logic                      header_pending_next;
  logic                      nal_closes_next;

  // Window and step results
  logic [WIN_DEPTH-1:0][7:0] wb;
  logic [WIN_DEPTH-1:0]      wf;
  logic [WIN_DEPTH-1:0]      wl;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          lo;
  logic [CNT_W-1:0]          s;
  logic [CNT_W-1:0]          rem;
  logic [CNT_W-1:0]          new_lo;
  logic [CNT_W-1:0]          keep;
  logic [CNT_W:0]            idx;
  logic                      fin;

  always_comb begin
    // Build the window: held bytes plus the incoming one
    wb = '0;
    wf = '0;
    wl = '0;
    for (int i = 0; i < DLY_DEPTH; i++) begin
      if (CNT_W'(i) < dly_count) begin
        wb[i] = dly_bytes[i];
        wf[i] = dly_first[i];
        wl[i] = dly_last[i];
      end
    end
    wb[dly_count] = stream_byte;
    n = dly_count + CNT_W'(1);

    // Parse start codes and NAL headers
    zero_run_next       = zero_run;
    header_pending_next = header_pending;
    nal_closes_next     = nal_closes;
    in_packet_next      = in_packet;
    lo                  = '0;
    s                   = '0;
    if (header_pending) begin
      nal_closes_next     = closing_type_mask[stream_byte[TYPE_BITS-1:0]];
      header_pending_next = 1'b0;
      zero_run_next       = '0;
    end else if (stream_byte == 8'h00) begin
      if (zero_run != 2'd3) begin
        zero_run_next = zero_run + 2'd1;
      end
    end else if (stream_byte == START_BYTE && zero_run >= 2'd2) begin
      // a fourth zero joins the code when the window holds it
      s = (zero_run == 2'd3 && n >= CNT_W'(4)) ? n - CNT_W'(4) : n - CNT_W'(3);
      if (!in_packet) begin
        lo             = s;
        wf[s]          = 1'b1;
        in_packet_next = 1'b1;
      end else if (nal_closes) begin
        wf[s] = 1'b1;
        if (s != '0) begin
          wl[s - CNT_W'(1)] = 1'b1;
        end
      end
      nal_closes_next     = 1'b0;
      header_pending_next = 1'b1;
      zero_run_next       = '0;
    end else begin
      zero_run_next = '0;
    end

    // Emit inside a packet: the window from lo on end of stream, else the oldest overflow byte
    rem    = n - lo;
    new_lo = (rem > CNT_W'(DLY_DEPTH)) ? lo + CNT_W'(1) : lo;
    if (end_of_stream) begin
      batch.cnt = in_packet_next ? rem : '0;
    end else begin
      batch.cnt = (rem > CNT_W'(DLY_DEPTH) && in_packet_next) ? CNT_W'(1) : '0;
    end
    for (int k = 0; k < MAX_RES; k++) begin
      idx = {1'b0, lo} + (CNT_W+1)'(k);
      fin = 1'b0;
      batch.res[k] = '0;
      if (idx < (CNT_W+1)'(WIN_DEPTH)) begin
        fin = end_of_stream && (idx[CNT_W-1:0] == n - CNT_W'(1));
        batch.res[k].data   = wb[idx[CNT_W-1:0]];
        batch.res[k].first  = wf[idx[CNT_W-1:0]];
        batch.res[k].last   = wl[idx[CNT_W-1:0]] | fin;
        batch.res[k].closed = fin;
      end
    end

    // Shift the kept bytes down into the delay line
    keep           = n - new_lo;
    dly_count_next = keep;
    dly_bytes_next = '0;
    dly_first_next = '0;
    dly_last_next  = '0;
    for (int i = 0; i < DLY_DEPTH; i++) begin
      idx = {1'b0, new_lo} + (CNT_W+1)'(i);
      if (CNT_W'(i) < keep && idx < (CNT_W+1)'(WIN_DEPTH)) begin
        dly_bytes_next[i] = wb[idx[CNT_W-1:0]];
        dly_first_next[i] = wf[idx[CNT_W-1:0]];
        dly_last_next[i]  = wl[idx[CNT_W-1:0]];
      end
    end

    // End of stream returns the stream state to reset
    if (end_of_stream) begin
      dly_count_next      = '0;
      zero_run_next       = '0;
      in_packet_next      = 1'b0;
      header_pending_next = 1'b0;
      nal_closes_next     = 1'b0;
    end
  end

  // Advance the stream state once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_count      <= '0;
      zero_run       <= '0;
      in_packet      <= 1'b0;
      header_pending <= 1'b0;
      nal_closes     <= 1'b0;
    end else if (fire) begin
      dly_count      <= dly_count_next;
      zero_run       <= zero_run_next;
      in_packet      <= in_packet_next;
      header_pending <= header_pending_next;
      nal_closes     <= nal_closes_next;
    end
  end

  // Hold delay line payload
  always_ff @(posedge clk) begin
    if (fire) begin
      dly_bytes <= dly_bytes_next;
      dly_first <= dly_first_next;
      dly_last  <= dly_last_next;
    end
  end

endmodule

>>> design/nalsplit_outq.sv
// Result queue: takes a batch of up to five results, drains one per cycle while out_ready is high.
`timescale 1ns / 1ps
module nalsplit_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  nalsplit_pkg::batch_t batch,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nalsplit_pkg::res_t   head
);
  import nalsplit_pkg::*;

  res_t [Q_DEPTH-1:0] q;
  res_t [Q_DEPTH-1:0] q_next;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;
  logic [QCNT_W-1:0]  left;
  logic               pop;
  logic               base;
  logic [3:0]         off;

  assign out_valid = (count != '0);
  assign head      = q[0];
  assign pop       = out_valid && out_ready;
  assign left      = count - QCNT_W'(pop);
  // room for a full batch behind at most one waiting result
  assign can_push  = (left <= QCNT_W'(1));
  assign base      = left[0];

  always_comb begin
    // Shift out the taken transaction, then place the new batch behind the rest
    for (int j = 0; j < Q_DEPTH; j++) begin
      if (pop && j < Q_DEPTH - 1) begin
        q_next[j] = q[j + 1];
      end else begin
        q_next[j] = q[j];
      end
      off = 4'(j) - 4'(base);
      if (push && 4'(j) >= 4'(base) && off < 4'(batch.cnt)
          && off < 4'(MAX_RES)) begin
        q_next[j] = batch.res[off[CNT_W-1:0]];
      end
    end
    count_next = left + (push ? QCNT_W'(batch.cnt) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> design/annexb_nal_access_unit_splitter.sv
// Top level of the H.264 Annex B access unit splitter.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    stream_byte, end_of_stream
//   out       output     out_valid/out_ready  packet_byte, first_of_packet,
//                                             last_of_packet, closed_by_end
//   cfg       input      cfg_wr_en            cfg_wr_data (closing type mask)
//
// One byte is accepted per cycle while the queue has room. A byte waits in the
// input register until the result queue takes its results, which leave from
// its head register. An end-of-stream byte flushes up to five results, drained
// one per cycle while out_ready is high, and input stalls while they drain.
// Packet bytes leave four bytes behind the input. Reset clears the stream
// state and loads mask 0x22; output stalls back up the queue to in_ready.
`timescale 1ns / 1ps
module annexb_nal_access_unit_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_byte,
  output logic        first_of_packet,
  output logic        last_of_packet,
  output logic        closed_by_end,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import nalsplit_pkg::*;

  logic [31:0] closing_type_mask;
  logic        ir_valid;
  logic [7:0]  ir_byte;
  logic        ir_eos;
  logic        fire;
  logic        can_push;
  batch_t      batch;
  res_t        head;

  assign fire     = ir_valid && can_push;
  assign in_ready = !ir_valid || fire;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      closing_type_mask <= MASK_RESET;
    end else if (cfg_wr_en) begin
      closing_type_mask <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else begin
      ir_valid <= (in_valid && in_ready) || (ir_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte <= stream_byte;
      ir_eos  <= end_of_stream;
    end
  end

  nalsplit_step u_step (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .stream_byte       (ir_byte),
    .end_of_stream     (ir_eos),
    .closing_type_mask (closing_type_mask),
    .batch             (batch)
  );

  nalsplit_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .batch     (batch),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign packet_byte     = head.data;
  assign first_of_packet = head.first;
  assign last_of_packet  = head.last;
  assign closed_by_end   = head.closed;

endmodule
